>>> design/mlpd_pkg.sv
`default_nettype none
package mlpd_pkg;

  // Width of a part length
  localparam int LEN_WIDTH = 16;

  // Marker and syntax bytes
  localparam logic [7:0] MK0       = 8'hEF;
  localparam logic [7:0] MK1       = 8'hBF;
  localparam logic [7:0] MK2       = 8'hBD;
  localparam logic [7:0] COLON     = 8'h3A;
  localparam logic [7:0] TYPE_LO   = 8'h33;  // '3'
  localparam logic [7:0] TYPE_HI   = 8'h35;  // '5'
  localparam logic [7:0] DIGIT_LO  = 8'h30;
  localparam logic [7:0] DIGIT_HI  = 8'h39;

  // Result kinds
  localparam logic [1:0] KIND_BODY = 2'd0;
  localparam logic [1:0] KIND_LAST = 2'd1;
  localparam logic [1:0] KIND_NOOP = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  // Error causes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_SHORT   = 3'd1;
  localparam logic [2:0] ERR_MARKER  = 3'd2;
  localparam logic [2:0] ERR_EMPTY   = 3'd3;
  localparam logic [2:0] ERR_TYPE    = 3'd4;
  localparam logic [2:0] ERR_LENGTH  = 3'd5;

  // Parse phases, one-hot
  typedef enum logic [10:0] {
    PH_D0     = 11'b000_0000_0001,
    PH_D1     = 11'b000_0000_0010,
    PH_D2     = 11'b000_0000_0100,
    PH_SINGLE = 11'b000_0000_1000,
    PH_EF     = 11'b000_0001_0000,
    PH_BF     = 11'b000_0010_0000,
    PH_BD     = 11'b000_0100_0000,
    PH_DIGITS = 11'b000_1000_0000,
    PH_BF2    = 11'b001_0000_0000,
    PH_BD2    = 11'b010_0000_0000,
    PH_PART   = 11'b100_0000_0000
  } phase_t;

  // Outcome of one message byte
  typedef struct packed {
    logic       emit;
    logic       fail;
    logic [1:0] kind;
    logic [1:0] msg_type;
    logic [2:0] cause;
    logic [7:0] first_byte;
    logic [1:0] noop_colons;
    logic [1:0] colon_count;
  } msg_res_t;

  // One byte of a message at position pos (saturated at 3)
  function automatic msg_res_t msg_byte(
    input logic [7:0] b,
    input logic [1:0] pos,
    input logic       last,
    input logic [7:0] first_byte,
    input logic [1:0] noop_colons,
    input logic [1:0] colon_count
  );
    msg_res_t   r;
    logic [7:0] type_off;
    r = '0;
    r.first_byte  = (pos == 2'd0) ? b : first_byte;
    r.noop_colons = noop_colons;
    r.colon_count = colon_count;
    if ((pos == 2'd1 || pos == 2'd2) && b == COLON) begin
      r.noop_colons = noop_colons + 2'd1;
    end
    type_off = r.first_byte - TYPE_LO;
    if (colon_count != 2'd3) begin
      // still in the header of the message
      if (b == COLON) begin
        r.colon_count = colon_count + 2'd1;
      end
      if (last) begin
        r.emit = 1'b1;
        if (pos == 2'd2 && r.noop_colons == 2'd2) begin
          r.kind = KIND_NOOP;
        end else begin
          r.fail  = 1'b1;
          r.kind  = KIND_ERR;
          r.cause = ERR_EMPTY;
        end
      end
    end else if (r.first_byte < TYPE_LO || r.first_byte > TYPE_HI) begin
      r.emit  = 1'b1;
      r.fail  = 1'b1;
      r.kind  = KIND_ERR;
      r.cause = ERR_TYPE;
    end else begin
      r.emit     = 1'b1;
      r.kind     = last ? KIND_LAST : KIND_BODY;
      r.msg_type = type_off[1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/marked_length_part_deframer.sv
`default_nettype none
// Channel   Dir  Fields
// s_axis    in   tdata[7:0] data_byte, tlast end_of_body
// m_axis    out  tdata[7:0] body_byte, [9:8] msg_type, [12:10] error_cause;
//                tuser[1:0] kind
//
// One byte per cycle; a byte's result shows on m_axis the cycle after it is taken.
// The parse state and the single output register are updated in the same cycle.
// rst (synchronous) returns the parser to the start of a body.
// s_axis_tready drops only while a result is held and m_axis_tready is low.
module marked_length_part_deframer
  import mlpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] body_byte, [9:8] msg_type,
                                           // [12:10] error_cause, rest zero
  output logic [1:0]       m_axis_tuser    // [1:0] kind
);

  // Parser state
  phase_t                 phase, phase_next;
  logic [2:0]             body_count, body_count_next;
  logic [LEN_WIDTH-1:0]   part_length, part_length_next;
  logic [LEN_WIDTH-1:0]   part_remaining, part_remaining_next;
  logic [1:0]             colon_count, colon_count_next;
  logic [7:0]             first_byte, first_byte_next;
  logic [1:0]             noop_colons, noop_colons_next;
  logic                   failed, failed_next;

  // Output register
  logic                   out_valid;
  logic [1:0]             out_kind;
  logic [7:0]             out_body;
  logic [1:0]             out_type;
  logic [2:0]             out_cause;

  // Step results
  logic                   emit;
  logic [1:0]             res_kind;
  logic [7:0]             res_body;
  logic [1:0]             res_type;
  logic [2:0]             res_cause;

  logic                   accept;
  logic [7:0]             b;
  logic                   eob;
  logic                   is_digit;
  logic [LEN_WIDTH+3:0]   len_times10;
  logic [LEN_WIDTH-1:0]   part_pos;
  logic                   part_last;
  logic                   mb_en;
  logic [1:0]             mb_pos;
  logic                   mb_last;
  msg_res_t               mb;

  assign b      = s_axis_tdata;
  assign eob    = s_axis_tlast;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;

  // Length arithmetic
  assign is_digit    = (b >= DIGIT_LO) && (b <= DIGIT_HI);
  assign len_times10 = {1'b0, part_length, 3'b000} + {3'b000, part_length, 1'b0}
                     + {{LEN_WIDTH{1'b0}}, b[3:0]};
  assign part_pos    = part_length - part_remaining;
  assign part_last   = (part_remaining <= {{(LEN_WIDTH-1){1'b0}}, 1'b1});

  // Next state and result for one byte
  always_comb begin
    phase_next          = phase;
    body_count_next     = (body_count < 3'd4) ? body_count + 3'd1 : body_count;
    part_length_next    = part_length;
    part_remaining_next = part_remaining;
    colon_count_next    = colon_count;
    first_byte_next     = first_byte;
    noop_colons_next    = noop_colons;
    failed_next         = failed;
    emit                = 1'b0;
    res_kind            = KIND_ERR;
    res_body            = 8'd0;
    res_type            = 2'd0;
    res_cause           = ERR_NONE;
    mb_en               = 1'b0;
    mb_pos              = 2'd0;
    mb_last             = eob;
    mb                  = '0;

    if (!failed) begin
      if (eob && body_count < 3'd3) begin
        emit      = 1'b1;
        res_cause = ERR_SHORT;
      end else begin
        unique case (phase)
          PH_D0: begin
            phase_next = (b == MK0) ? PH_D1 : PH_SINGLE;
            mb_en      = 1'b1;
            mb_pos     = 2'd0;
          end
          PH_D1: begin
            phase_next = (b == MK1) ? PH_D2 : PH_SINGLE;
            mb_en      = 1'b1;
            mb_pos     = 2'd1;
          end
          PH_D2: begin
            if (b == MK2) begin
              colon_count_next = 2'd0;
              first_byte_next  = 8'd0;
              noop_colons_next = 2'd0;
              part_length_next = '0;
              phase_next       = PH_DIGITS;
            end else begin
              phase_next = PH_SINGLE;
              mb_en      = 1'b1;
              mb_pos     = 2'd2;
            end
          end
          PH_SINGLE: begin
            mb_en  = 1'b1;
            mb_pos = (body_count >= 3'd3) ? 2'd3 : body_count[1:0];
          end
          PH_EF: begin
            if (b != MK0 || eob) begin
              emit      = 1'b1;
              res_cause = ERR_MARKER;
            end else begin
              phase_next = PH_BF;
            end
          end
          PH_BF: begin
            if (b != MK1 || eob) begin
              emit      = 1'b1;
              res_cause = ERR_MARKER;
            end else begin
              phase_next = PH_BD;
            end
          end
          PH_BD: begin
            if (b != MK2 || eob) begin
              emit      = 1'b1;
              res_cause = ERR_MARKER;
            end else begin
              part_length_next = '0;
              phase_next       = PH_DIGITS;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              if (len_times10[LEN_WIDTH+3:LEN_WIDTH] != 4'd0) begin
                emit      = 1'b1;
                res_cause = ERR_LENGTH;
              end else begin
                part_length_next = len_times10[LEN_WIDTH-1:0];
                if (eob) begin
                  emit      = 1'b1;
                  res_cause = ERR_MARKER;
                end
              end
            end else if (b != MK0 || eob) begin
              emit      = 1'b1;
              res_cause = ERR_MARKER;
            end else begin
              phase_next = PH_BF2;
            end
          end
          PH_BF2: begin
            if (b != MK1 || eob) begin
              emit      = 1'b1;
              res_cause = ERR_MARKER;
            end else begin
              phase_next = PH_BD2;
            end
          end
          PH_BD2: begin
            if (b != MK2 || eob) begin
              emit      = 1'b1;
              res_cause = ERR_MARKER;
            end else if (part_length == '0) begin
              emit      = 1'b1;
              res_cause = ERR_EMPTY;
            end else begin
              part_remaining_next = part_length;
              colon_count_next    = 2'd0;
              first_byte_next     = 8'd0;
              noop_colons_next    = 2'd0;
              phase_next          = PH_PART;
            end
          end
          PH_PART: begin
            if (eob && !part_last) begin
              emit      = 1'b1;
              res_cause = ERR_MARKER;
            end else begin
              mb_en   = 1'b1;
              mb_last = part_last;
              mb_pos  = (part_pos > {{(LEN_WIDTH-2){1'b0}}, 2'd3}) ? 2'd3 : part_pos[1:0];
              if (part_last) begin
                part_remaining_next = '0;
                phase_next          = PH_EF;
              end else begin
                part_remaining_next = part_remaining - {{(LEN_WIDTH-1){1'b0}}, 1'b1};
              end
            end
          end
          default: begin
            emit      = 1'b1;
            res_cause = ERR_MARKER;
          end
        endcase
      end

      // A header error stops the body
      if (emit) begin
        failed_next = 1'b1;
      end

      // Fold in the message byte outcome
      if (mb_en) begin
        mb               = msg_byte(b, mb_pos, mb_last, first_byte, noop_colons,
                                    colon_count);
        first_byte_next  = mb.first_byte;
        noop_colons_next = mb.noop_colons;
        colon_count_next = mb.colon_count;
        emit             = mb.emit;
        res_kind         = mb.kind;
        res_body         = (mb.kind == KIND_BODY || mb.kind == KIND_LAST) ? b : 8'd0;
        res_type         = mb.msg_type;
        res_cause        = mb.cause;
        failed_next      = mb.fail;
      end
    end

    // End of body returns to the start
    if (eob) begin
      phase_next          = PH_D0;
      body_count_next     = 3'd0;
      part_length_next    = '0;
      part_remaining_next = '0;
      colon_count_next    = 2'd0;
      first_byte_next     = 8'd0;
      noop_colons_next    = 2'd0;
      failed_next         = 1'b0;
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_D0;
      body_count     <= 3'd0;
      part_length    <= '0;
      part_remaining <= '0;
      colon_count    <= 2'd0;
      first_byte     <= 8'd0;
      noop_colons    <= 2'd0;
      failed         <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      body_count     <= body_count_next;
      part_length    <= part_length_next;
      part_remaining <= part_remaining_next;
      colon_count    <= colon_count_next;
      first_byte     <= first_byte_next;
      noop_colons    <= noop_colons_next;
      failed         <= failed_next;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_kind  <= res_kind;
      out_body  <= res_body;
      out_type  <= res_type;
      out_cause <= res_cause;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_cause, out_type, out_body};
  assign m_axis_tuser  = out_kind;

endmodule
`default_nettype wire
